/* rtl/core/lfu_cache_lru_tiebreak_assert.svh */
// assertion macros for the lfu cache
`ifndef LFU_CACHE_LRU_TIEBREAK_ASSERT_SVH
`define LFU_CACHE_LRU_TIEBREAK_ASSERT_SVH

// same-cycle implication under the block clock and reset
`define LFU_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lfu check failed");

// next-cycle implication under the block clock and reset
`define LFU_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lfu check failed");

`endif

/* rtl/core/lfu_pkg.sv */
package lfu_pkg;

    localparam int ENTRIES    = 16;
    localparam int COUNT_BITS = 16;
    localparam int KEY_W      = 32;
    localparam int VAL_W      = 32;
    localparam int STAMP_W    = 32;
    localparam int CFG_W      = 5;
    localparam int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int FILL_W     = $clog2(ENTRIES + 1);
    localparam int CMP_W      = (FILL_W > CFG_W) ? FILL_W : CFG_W;

    localparam logic [CFG_W-1:0]      CAP_RESET = CFG_W'(16);
    localparam logic [VAL_W-1:0]      NO_VALUE  = {VAL_W{1'b1}};
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic                  MODE_GET  = 1'b0;
    localparam logic                  MODE_SET  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic                    mode;
        logic signed [KEY_W-1:0] lookup_key;
        logic signed [VAL_W-1:0] write_value;
    } t_item;

    typedef struct packed {
        logic                    hit;
        logic signed [VAL_W-1:0] read_value;
    } t_result;

    typedef struct packed {
        logic                  valid;
        logic [KEY_W-1:0]      key;
        logic [VAL_W-1:0]      value;
        logic [COUNT_BITS-1:0] count;
        logic [STAMP_W-1:0]    stamp;
    } t_entry;

    typedef struct packed {
        logic                  en;
        logic [IDX_W-1:0]      idx;
        logic [KEY_W-1:0]      key;
        logic [VAL_W-1:0]      value;
        logic [COUNT_BITS-1:0] count;
        logic [STAMP_W-1:0]    stamp;
    } t_store_wr;

    typedef struct packed {
        logic             clear;
        logic             step;
        logic [IDX_W-1:0] idx;
    } t_scan_ctl;

    typedef struct packed {
        logic                  match;
        logic [IDX_W-1:0]      match_idx;
        logic [VAL_W-1:0]      match_value;
        logic [COUNT_BITS-1:0] match_count;
        logic                  free;
        logic [IDX_W-1:0]      free_idx;
        logic                  vict;
        logic [IDX_W-1:0]      vict_idx;
    } t_scan_res;

endpackage

/* rtl/core/lfu_cache_lru_tiebreak.sv */
// flow: an accepted word runs the entry scan (ST_SCAN), then ST_UPDATE, then ST_FINISH,
//   which loads the output register; a new word is taken only in ST_IDLE, after that,
//   and the scan steps one entry per cycle through a single shared compare unit;
//   a result still waiting in the output register holds the block until it drains
// reset: synchronous active-low i_rst_n clears all valid bits, touch clock and
//   fill count, sets capacity to 16; no clearing pass, ready right after reset
module lfu_cache_lru_tiebreak (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [lfu_pkg::CFG_W-1:0] i_cfg_wdata,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  lfu_pkg::t_item            i_item,
    output logic                      o_valid,
    input  logic                      i_ready,
    output lfu_pkg::t_result          o_result
);

    localparam logic [lfu_pkg::IDX_W-1:0] LAST_IDX = lfu_pkg::IDX_W'(lfu_pkg::ENTRIES - 1);

    lfu_pkg::t_state r_state, n_state;

    // control and bookkeeping
    logic [lfu_pkg::CFG_W-1:0]   r_cap;
    logic [lfu_pkg::STAMP_W-1:0] r_touch_clock, n_touch_clock;
    logic [lfu_pkg::FILL_W-1:0]  r_fill, n_fill;
    logic [lfu_pkg::IDX_W-1:0]   r_idx, n_idx;
    logic                        r_out_valid, n_out_valid;

    // payload
    lfu_pkg::t_item   r_item;
    lfu_pkg::t_result r_res, n_res;
    lfu_pkg::t_result r_out, n_out;

    lfu_pkg::t_scan_ctl scan_ctl;
    lfu_pkg::t_scan_res scan_res;
    lfu_pkg::t_entry    rd_entry;
    lfu_pkg::t_store_wr store_wr;

    logic                        accept;
    logic                        out_free;
    logic [lfu_pkg::CMP_W-1:0]   cap_eff;
    logic [lfu_pkg::CMP_W-1:0]   fill_ext;
    logic                        full;
    logic                        use_vict;

    assign accept   = i_valid && o_ready;
    assign out_free = !r_out_valid || i_ready;

    // effective capacity is the register clamped to the number of entries
    always_comb begin
        cap_eff = lfu_pkg::CMP_W'(r_cap);
        if (cap_eff > lfu_pkg::CMP_W'(lfu_pkg::ENTRIES)) begin
            cap_eff = lfu_pkg::CMP_W'(lfu_pkg::ENTRIES);
        end
    end
    assign fill_ext = lfu_pkg::CMP_W'(r_fill);
    assign full     = fill_ext >= cap_eff;
    // evict when full, or when no free slot turned up in the scan
    assign use_vict = full || !scan_res.free;

    lfu_store u_store (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rd_idx (r_idx),
        .i_wr     (store_wr),
        .o_rd     (rd_entry)
    );

    lfu_scan u_scan (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (scan_ctl),
        .i_entry       (rd_entry),
        .i_key         (r_item.lookup_key),
        .i_touch_clock (r_touch_clock),
        .o_res         (scan_res)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lfu_pkg::ST_IDLE: begin
                if (accept) begin
                    n_state = lfu_pkg::ST_SCAN;
                end
            end
            lfu_pkg::ST_SCAN: begin
                if (r_idx == LAST_IDX) begin
                    n_state = lfu_pkg::ST_UPDATE;
                end
            end
            lfu_pkg::ST_UPDATE: begin
                n_state = lfu_pkg::ST_FINISH;
            end
            lfu_pkg::ST_FINISH: begin
                if (out_free) begin
                    n_state = lfu_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = lfu_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs and datapath control
    always_comb begin
        o_ready        = 1'b0;
        scan_ctl.clear = 1'b0;
        scan_ctl.step  = 1'b0;
        scan_ctl.idx   = r_idx;
        n_idx          = r_idx;
        n_touch_clock  = r_touch_clock;
        n_fill         = r_fill;
        n_res          = r_res;
        n_out          = r_out;
        n_out_valid    = r_out_valid;
        store_wr.en    = 1'b0;
        store_wr.idx   = scan_res.match_idx;
        store_wr.key   = r_item.lookup_key;
        store_wr.value = r_item.write_value;
        store_wr.count = lfu_pkg::COUNT_BITS'(1);
        store_wr.stamp = r_touch_clock;

        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            lfu_pkg::ST_IDLE: begin
                o_ready        = 1'b1;
                scan_ctl.clear = 1'b1;
                n_idx          = '0;
            end
            lfu_pkg::ST_SCAN: begin
                scan_ctl.step = 1'b1;
                n_idx         = r_idx + 1'b1;
            end
            lfu_pkg::ST_UPDATE: begin
                n_res.hit        = 1'b0;
                n_res.read_value = lfu_pkg::NO_VALUE;
                if (cap_eff != '0) begin
                    if (scan_res.match) begin
                        // hit: refresh value on set, bump count, stamp touch
                        n_res.hit   = 1'b1;
                        store_wr.en = 1'b1;
                        if (r_item.mode == lfu_pkg::MODE_GET) begin
                            n_res.read_value = scan_res.match_value;
                            store_wr.value   = scan_res.match_value;
                        end
                        if (scan_res.match_count != lfu_pkg::COUNT_MAX) begin
                            store_wr.count = scan_res.match_count + 1'b1;
                        end else begin
                            store_wr.count = scan_res.match_count;
                        end
                        n_touch_clock = r_touch_clock + 1'b1;
                    end else if (r_item.mode == lfu_pkg::MODE_SET) begin
                        // insert with count 1, reusing the victim slot when full or no slot is free
                        if (use_vict) begin
                            store_wr.idx = scan_res.vict_idx;
                            store_wr.en  = scan_res.vict;
                        end else begin
                            store_wr.idx = scan_res.free_idx;
                            store_wr.en  = 1'b1;
                            n_fill       = r_fill + 1'b1;
                        end
                        if (store_wr.en) begin
                            n_touch_clock = r_touch_clock + 1'b1;
                        end
                    end
                end
            end
            lfu_pkg::ST_FINISH: begin
                if (out_free) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                end
            end
            default: begin
                o_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= lfu_pkg::ST_IDLE;
            r_cap         <= lfu_pkg::CAP_RESET;
            r_touch_clock <= '0;
            r_fill        <= '0;
            r_idx         <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_touch_clock <= n_touch_clock;
            r_fill        <= n_fill;
            r_idx         <= n_idx;
            r_out_valid   <= n_out_valid;
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
        end
    end

    // item and result payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_item;
        end
        r_res <= n_res;
        r_out <= n_out;
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

/* rtl/core/lfu_store.sv */
module lfu_store (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [lfu_pkg::IDX_W-1:0] i_rd_idx,
    input  lfu_pkg::t_store_wr    i_wr,
    output lfu_pkg::t_entry       o_rd
);

    logic [lfu_pkg::ENTRIES-1:0]    r_valid;
    logic [lfu_pkg::KEY_W-1:0]      r_key   [lfu_pkg::ENTRIES];
    logic [lfu_pkg::VAL_W-1:0]      r_value [lfu_pkg::ENTRIES];
    logic [lfu_pkg::COUNT_BITS-1:0] r_count [lfu_pkg::ENTRIES];
    logic [lfu_pkg::STAMP_W-1:0]    r_stamp [lfu_pkg::ENTRIES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr.en) begin
            r_valid[i_wr.idx] <= 1'b1;
        end
    end

    // entry payload, only read while valid
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_key[i_wr.idx]   <= i_wr.key;
            r_value[i_wr.idx] <= i_wr.value;
            r_count[i_wr.idx] <= i_wr.count;
            r_stamp[i_wr.idx] <= i_wr.stamp;
        end
    end

    always_comb begin
        o_rd.valid = r_valid[i_rd_idx];
        o_rd.key   = r_key[i_rd_idx];
        o_rd.value = r_value[i_rd_idx];
        o_rd.count = r_count[i_rd_idx];
        o_rd.stamp = r_stamp[i_rd_idx];
    end

endmodule

/* rtl/core/lfu_scan.sv */
module lfu_scan (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  lfu_pkg::t_scan_ctl          i_ctl,
    input  lfu_pkg::t_entry             i_entry,
    input  logic [lfu_pkg::KEY_W-1:0]   i_key,
    input  logic [lfu_pkg::STAMP_W-1:0] i_touch_clock,
    output lfu_pkg::t_scan_res          o_res
);

    logic                           r_match, n_match;
    logic [lfu_pkg::IDX_W-1:0]      r_match_idx, n_match_idx;
    logic [lfu_pkg::VAL_W-1:0]      r_match_value, n_match_value;
    logic [lfu_pkg::COUNT_BITS-1:0] r_match_count, n_match_count;
    logic                           r_free, n_free;
    logic [lfu_pkg::IDX_W-1:0]      r_free_idx, n_free_idx;
    logic                           r_vict, n_vict;
    logic [lfu_pkg::IDX_W-1:0]      r_vict_idx, n_vict_idx;
    logic [lfu_pkg::COUNT_BITS-1:0] r_vict_count, n_vict_count;
    logic [lfu_pkg::STAMP_W-1:0]    r_vict_age, n_vict_age;
    logic [lfu_pkg::STAMP_W-1:0]    age;
    logic                           better;

    // age wraps modulo the stamp width
    assign age    = i_touch_clock - i_entry.stamp;
    assign better = !r_vict || (i_entry.count < r_vict_count) ||
                    ((i_entry.count == r_vict_count) && (age > r_vict_age));

    always_comb begin
        n_match       = r_match;
        n_match_idx   = r_match_idx;
        n_match_value = r_match_value;
        n_match_count = r_match_count;
        n_free        = r_free;
        n_free_idx    = r_free_idx;
        n_vict        = r_vict;
        n_vict_idx    = r_vict_idx;
        n_vict_count  = r_vict_count;
        n_vict_age    = r_vict_age;
        if (i_ctl.clear) begin
            n_match = 1'b0;
            n_free  = 1'b0;
            n_vict  = 1'b0;
        end else if (i_ctl.step) begin
            if (i_entry.valid) begin
                if (!r_match && (i_entry.key == i_key)) begin
                    n_match       = 1'b1;
                    n_match_idx   = i_ctl.idx;
                    n_match_value = i_entry.value;
                    n_match_count = i_entry.count;
                end
                if (better) begin
                    n_vict       = 1'b1;
                    n_vict_idx   = i_ctl.idx;
                    n_vict_count = i_entry.count;
                    n_vict_age   = age;
                end
            end else if (!r_free) begin
                n_free     = 1'b1;
                n_free_idx = i_ctl.idx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match <= 1'b0;
            r_free  <= 1'b0;
            r_vict  <= 1'b0;
        end else begin
            r_match <= n_match;
            r_free  <= n_free;
            r_vict  <= n_vict;
        end
    end

    always_ff @(posedge i_clk) begin
        r_match_idx   <= n_match_idx;
        r_match_value <= n_match_value;
        r_match_count <= n_match_count;
        r_free_idx    <= n_free_idx;
        r_vict_idx    <= n_vict_idx;
        r_vict_count  <= n_vict_count;
        r_vict_age    <= n_vict_age;
    end

    always_comb begin
        o_res.match       = r_match;
        o_res.match_idx   = r_match_idx;
        o_res.match_value = r_match_value;
        o_res.match_count = r_match_count;
        o_res.free        = r_free;
        o_res.free_idx    = r_free_idx;
        o_res.vict        = r_vict;
        o_res.vict_idx    = r_vict_idx;
    end

endmodule

/* rtl/core/lfu_checker.sv */
`include "lfu_cache_lru_tiebreak_assert.svh"

module lfu_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_valid,
    input logic             o_ready,
    input lfu_pkg::t_item   i_item,
    input logic             o_valid,
    input logic             i_ready,
    input lfu_pkg::t_result o_result
);

    // a stalled result word holds
    `LFU_ASSERT_NEXT(a_out_hold, o_valid && !i_ready, o_valid && $stable(o_result))

    // one word at a time: ready drops right after an accept
    `LFU_ASSERT_NEXT(a_busy_after_accept, i_valid && o_ready, !o_ready)

    // a miss never carries a stored value
    `LFU_ASSERT_NOW(a_miss_no_value, o_valid && !o_result.hit, o_result.read_value == -32'sd1)

endmodule

bind lfu_cache_lru_tiebreak lfu_checker u_lfu_checker (.*);
